@@ hw/rtl/rte_pkg.sv @@
// Shared types and constants for the Riemann tensor engine.
package rte_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IDX_W = 2;
  localparam int ACC_W = 63;
  localparam int SQ_W = 56;
  localparam int DACC_W = 40;
  localparam int GSUM_W = 52;
  localparam int DVD_W = 54;
  localparam int TOT_W = 56;
  localparam int STEP_W = 31;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 112;

  localparam logic [STEP_W-1:0] INV_STEP_RESET = 31'd65536;
  localparam logic [ACC_W-1:0] THRESHOLD_RESET = 63'd167772160000000000;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  localparam logic [2:0] TSEL_CENTRAL = 3'd0;
  localparam logic [2:0] TSEL_MINUS_HALF = 3'd4;

  localparam logic CFG_INV_STEP = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_READ,
    ENG_MULT,
    ENG_ADD,
    ENG_DIV,
    ENG_FIN,
    ENG_DONE
  } eng_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_START,
    T_WAIT,
    T_SQ,
    T_ACC,
    T_EMIT
  } top_state_t;

  typedef struct packed {
    logic             we_c;
    logic             we_s;
    logic [5:0]       addr_c;
    logic [9:0]       addr_s;
    logic [VALUE_BITS-1:0] data;
  } load_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] rho;
    logic [IDX_W-1:0] sg;
    logic [IDX_W-1:0] mu;
    logic [IDX_W-1:0] nu;
  } eng_ctl_t;

  typedef struct packed {
    logic                  done;
    logic                  clip;
    logic [VALUE_BITS-1:0] comp;
  } eng_stat_t;

endpackage

@@ hw/rtl/riemann_tensor_engine_core.sv @@
// Top level of the Riemann tensor engine: request decode, component sequencing, accumulator.
//
// Input items on s_axis: tuser 0 loads one Christoffel value into the central
// table or a shifted table, tuser 1 asks for all components of one rho.
// A load does not stall the input; the next item may follow on the next cycle.
// A compute item produces DIMENSION^3 result items on m_axis in sigma, mu, nu
// order (nu fastest), tlast on the final one. Each component passes through
// the table reads over two memory ports, the two scaling multiplies and a
// three-step divide by three of the derivative part. s_axis_tready stays low
// while a request runs and during reset. The result register holds an item
// until it is taken; while the receiver stalls the sequencer waits before
// overwriting it. rho 0 clears the running sum of squares.
// Reset clears control, the accumulator and the configuration registers
// (inv_step 1.0, default threshold); table memories are not cleared and
// must be written before they are used.
// cfg_we/cfg_index/cfg_data write inv_step (0) and singular_threshold (1).
module riemann_tensor_engine_core
  import rte_pkg::*;
#(
  parameter int DIMENSION = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // table_sel, direction, idx_a, idx_b, idx_c, sym_value, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_rho, out_sigma, out_mu, out_nu, component, clipped, curvature_sum, singular, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [ACC_W-1:0]      cfg_data
);

  localparam logic [2:0] DIM3 = 3'(DIMENSION);
  localparam logic [IDX_W-1:0] DM1 = IDX_W'(DIMENSION - 1);

  top_state_t state, state_next;
  logic [STEP_W-1:0] inv_step;
  logic [ACC_W-1:0] threshold;
  logic [ACC_W-1:0] acc;
  logic [SQ_W-1:0] sq;
  logic [IDX_W-1:0] rho, sg, mu, nu;

  logic [2:0] tsel, tsel_m1;
  logic [1:0] dir, ia, ib, ic;
  logic [VALUE_BITS-1:0] sym;
  logic in_acc, idx_ok, dir_ok, is_last, emit_go, out_free;

  load_t ld;
  eng_ctl_t ctl;
  eng_stat_t stat;

  logic [VALUE_BITS-1:0] cmag;
  logic [2*VALUE_BITS-1:0] sq_full;
  logic [ACC_W:0] acc_sum;

  logic [IDX_W-1:0] o_rho, o_sg, o_mu, o_nu;
  logic [VALUE_BITS-1:0] o_comp;
  logic o_clip, o_sing, o_last;
  logic [ACC_W-1:0] o_sum;

  assign tsel = s_axis_tdata[2:0];
  assign dir  = s_axis_tdata[4:3];
  assign ia   = s_axis_tdata[6:5];
  assign ib   = s_axis_tdata[8:7];
  assign ic   = s_axis_tdata[10:9];
  assign sym  = s_axis_tdata[42:11];
  assign tsel_m1 = tsel - 3'd1;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign idx_ok  = ({1'b0, ia} < DIM3) && ({1'b0, ib} < DIM3) && ({1'b0, ic} < DIM3);
  assign dir_ok  = {1'b0, dir} < DIM3;
  assign is_last = (sg == DM1) && (mu == DM1) && (nu == DM1);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    ld.we_c   = in_acc && (s_axis_tuser[0] == REQ_LOAD) && idx_ok && (tsel == TSEL_CENTRAL);
    ld.we_s   = in_acc && (s_axis_tuser[0] == REQ_LOAD) && idx_ok && dir_ok &&
                (tsel != TSEL_CENTRAL) && (tsel <= TSEL_MINUS_HALF);
    ld.addr_c = {ia, ib, ic};
    ld.addr_s = {tsel_m1[1:0], dir, ia, ib, ic};
    ld.data   = sym;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (in_acc && s_axis_tuser[0] == REQ_COMPUTE && {1'b0, ia} < DIM3)
                 state_next = T_START;
      T_START: state_next = T_WAIT;
      T_WAIT:  if (stat.done) state_next = T_SQ;
      T_SQ:    state_next = T_ACC;
      T_ACC:   state_next = T_EMIT;
      T_EMIT:  if (out_free) state_next = is_last ? T_IDLE : T_START;
      default: state_next = T_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == T_IDLE) && !rst;
    emit_go       = (state == T_EMIT) && out_free;
    ctl.start     = (state == T_START);
    ctl.rho       = rho;
    ctl.sg        = sg;
    ctl.mu        = mu;
    ctl.nu        = nu;
  end

  rte_engine #(
    .DIMENSION(DIMENSION)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .ctl      (ctl),
    .inv_step (inv_step),
    .stat     (stat)
  );

  assign cmag    = stat.comp[VALUE_BITS-1] ? VALUE_BITS'(-stat.comp) : stat.comp;
  assign sq_full = cmag * cmag;
  assign acc_sum = {1'b0, acc} + {{(ACC_W+1-SQ_W){1'b0}}, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      inv_step      <= INV_STEP_RESET;
      threshold     <= THRESHOLD_RESET;
      acc           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index[0])
          CFG_INV_STEP:  inv_step  <= cfg_data[STEP_W-1:0];
          CFG_THRESHOLD: threshold <= cfg_data;
          default: ;
        endcase
      end
      if (state == T_IDLE && state_next == T_START && ia == '0) acc <= '0;
      if (state == T_ACC) acc <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
      if (emit_go) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_IDLE) begin
      rho <= ia;
      sg  <= '0;
      mu  <= '0;
      nu  <= '0;
    end else if (emit_go) begin
      if (nu == DM1) begin
        nu <= '0;
        if (mu == DM1) begin
          mu <= '0;
          sg <= sg + 1'b1;
        end else begin
          mu <= mu + 1'b1;
        end
      end else begin
        nu <= nu + 1'b1;
      end
    end
    if (state == T_SQ) sq <= sq_full[2*VALUE_BITS-1:8];
    if (emit_go) begin
      o_rho  <= rho;
      o_sg   <= sg;
      o_mu   <= mu;
      o_nu   <= nu;
      o_comp <= stat.comp;
      o_clip <= stat.clip;
      o_sum  <= acc;
      o_sing <= acc > threshold;
      o_last <= is_last;
    end
  end

  assign m_axis_tdata = {7'd0, o_sing, o_sum, o_clip, o_comp, o_nu, o_mu, o_sg, o_rho};
  assign m_axis_tlast = o_last;

endmodule

@@ hw/rtl/rte_engine.sv @@
// Table memories and the per-component datapath (derivatives, Gamma products, scaling).
module rte_engine
  import rte_pkg::*;
#(
  parameter int DIMENSION = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  load_t             ld,
  input  eng_ctl_t          ctl,
  input  logic [STEP_W-1:0] inv_step,
  output eng_stat_t         stat
);

  localparam int CNT_W = 6;
  localparam int DIG_W = 18;
  localparam int DIV_STEPS = DVD_W / DIG_W;
  localparam logic [CNT_W-1:0] RD_LAST = CNT_W'(2 * DIMENSION + 1);
  localparam logic [CNT_W-1:0] RD_ISSUE = CNT_W'(2 * DIMENSION);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] S_ISSUE = CNT_W'(4);
  // (2^21 + 1) / 3: exact quotient by three for operands below 2^20
  localparam logic [DIG_W+1:0] RECIP3 = 20'd699051;
  localparam logic signed [TOT_W-1:0] COMP_MAX = TOT_W'({1'b0, {(VALUE_BITS-1){1'b1}}});
  localparam logic signed [TOT_W-1:0] COMP_MIN = ~COMP_MAX;

  logic signed [VALUE_BITS-1:0] cmem [64];
  logic signed [VALUE_BITS-1:0] smem [1024];

  eng_state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] rho, sg, mu, nu;

  logic [5:0] ca_addr, cb_addr;
  logic [9:0] sa_addr, sb_addr;
  logic iss_c, iss_s;
  logic [1:0] lam, kind;
  logic ph;

  logic signed [VALUE_BITS-1:0] ca_q, cb_q, sa_q, sb_q;
  logic p1_c, p1_s, p2_c;
  logic p1_ph, p2_ph;
  logic [1:0] p1_kind;
  logic signed [2*VALUE_BITS-1:0] prod_q;

  logic signed [DACC_W-1:0] dacc, dterm;
  logic signed [GSUM_W-1:0] gsum, gterm;
  logic signed [VALUE_BITS:0] sdiff;
  logic [DACC_W-1:0] dmag;
  logic [51:0] hi_p;
  logic [47:0] lo_p;
  logic neg;
  logic [DVD_W-1:0] dvd, quo;
  logic [1:0] rem;
  logic [DIG_W+1:0] dval, drem;
  logic [2*DIG_W+3:0] dprod;
  logic [DIG_W-1:0] dq;
  logic signed [TOT_W-1:0] qs, total;
  logic signed [VALUE_BITS-1:0] comp_q;
  logic clip_q;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: if (ctl.start) state_next = ENG_READ;
      ENG_READ: if (cnt == RD_LAST) state_next = ENG_MULT;
      ENG_MULT: state_next = ENG_ADD;
      ENG_ADD:  state_next = ENG_DIV;
      ENG_DIV:  if (cnt == DIV_LAST) state_next = ENG_FIN;
      ENG_FIN:  state_next = ENG_DONE;
      ENG_DONE: state_next = ENG_IDLE;
      default:  state_next = ENG_IDLE;
    endcase
  end

  // read issue
  always_comb begin
    lam   = cnt[2:1];
    ph    = cnt[0];
    kind  = cnt[1:0];
    iss_c = (state == ENG_READ) && (cnt < RD_ISSUE);
    iss_s = (state == ENG_READ) && (cnt < S_ISSUE);
    ca_addr = ph ? {rho, nu, lam} : {rho, mu, lam};
    cb_addr = ph ? {lam, mu, sg} : {lam, nu, sg};
    sa_addr = {kind, mu, rho, nu, sg};
    sb_addr = {kind, nu, rho, mu, sg};
    stat.done = (state == ENG_DONE);
    stat.clip = clip_q;
    stat.comp = comp_q;
  end

  always_ff @(posedge clk) begin
    if (ld.we_c) cmem[ld.addr_c] <= ld.data;
    if (ld.we_s) smem[ld.addr_s] <= ld.data;
    ca_q <= cmem[ca_addr];
    cb_q <= cmem[cb_addr];
    sa_q <= smem[sa_addr];
    sb_q <= smem[sb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      cnt   <= '0;
      p1_c  <= 1'b0;
      p1_s  <= 1'b0;
      p2_c  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state != state_next) ? '0 : cnt + 1'b1;
      p1_c  <= iss_c;
      p1_s  <= iss_s;
      p2_c  <= p1_c;
    end
  end

  // derivative term: N = -G(+h) + G(-h) + 8 G(+h/2) - 8 G(-h/2)
  always_comb begin
    sdiff = $signed({sa_q[VALUE_BITS-1], sa_q}) - $signed({sb_q[VALUE_BITS-1], sb_q});
    unique case (p1_kind)
      2'd0: dterm = -DACC_W'(sdiff);
      2'd1: dterm = DACC_W'(sdiff);
      2'd2: dterm = DACC_W'(sdiff) <<< 3;
      2'd3: dterm = -(DACC_W'(sdiff) <<< 3);
      default: dterm = '0;
    endcase
    gterm = GSUM_W'(prod_q >>> 16);
    dmag  = dacc[DACC_W-1] ? DACC_W'(-dacc) : DACC_W'(dacc);
    dval  = {rem, dvd[DVD_W-1 -: DIG_W]};
    dprod = dval * RECIP3;
    dq    = dprod[21 +: DIG_W];
    drem  = dval - ({2'b00, dq} + {1'b0, dq, 1'b0});
    qs    = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    total = qs + TOT_W'(gsum);
  end

  always_ff @(posedge clk) begin
    p1_ph   <= ph;
    p1_kind <= kind;
    p2_ph   <= p1_ph;
    prod_q  <= ca_q * cb_q;
    if (state == ENG_IDLE && ctl.start) begin
      rho  <= ctl.rho;
      sg   <= ctl.sg;
      mu   <= ctl.mu;
      nu   <= ctl.nu;
      dacc <= '0;
      gsum <= '0;
    end else begin
      if (p1_s) dacc <= dacc + dterm;
      if (p2_c) gsum <= p2_ph ? gsum - gterm : gsum + gterm;
    end
    if (state == ENG_MULT) begin
      hi_p <= dmag[37:17] * inv_step;
      lo_p <= dmag[16:0] * inv_step;
      neg  <= dacc[DACC_W-1];
    end
    if (state == ENG_ADD) begin
      dvd <= {2'b00, hi_p} + {23'd0, lo_p[47:17]};
      quo <= '0;
      rem <= '0;
    end
    // divide by 3, one 18-bit digit per cycle
    if (state == ENG_DIV) begin
      dvd <= dvd << DIG_W;
      quo <= {quo[DVD_W-DIG_W-1:0], dq};
      rem <= drem[1:0];
    end
    if (state == ENG_FIN) begin
      if (total > COMP_MAX) begin
        comp_q <= {1'b0, {(VALUE_BITS-1){1'b1}}};
        clip_q <= 1'b1;
      end else if (total < COMP_MIN) begin
        comp_q <= {1'b1, {(VALUE_BITS-1){1'b0}}};
        clip_q <= 1'b1;
      end else begin
        comp_q <= VALUE_BITS'(total);
        clip_q <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/rte_checker.sv @@
// Port-level checks for the Riemann tensor engine, bound to the top level.
module rte_checker
  import rte_pkg::*;
#(
  parameter int DIMENSION = 4
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [0:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  localparam logic [2:0] DIM3 = 3'(DIMENSION);
  localparam logic [1:0] DM1 = 2'(DIMENSION - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == REQ_COMPUTE &&
      {1'b0, s_axis_tdata[6:5]} < DIM3 |=> !s_axis_tready)
    else $error("input taken during a compute request");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[40] |->
      m_axis_tdata[39:8] == 32'h7fffffff || m_axis_tdata[39:8] == 32'h80000000)
    else $error("clipped component not at a limit");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[3:2] == DM1 && m_axis_tdata[5:4] == DM1 && m_axis_tdata[7:6] == DM1)
    else $error("tlast on a component that is not the final one");

endmodule

bind riemann_tensor_engine_core rte_checker #(.DIMENSION(DIMENSION)) u_rte_checker (.*);
